@@ hw/rtl/button_hold_time_tracker_defines.svh @@
// Assertion macros for the button hold time tracker RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef BUTTON_HOLD_TIME_TRACKER_DEFINES_SVH
`define BUTTON_HOLD_TIME_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BHTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BHTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bhtt_pkg.sv @@
// Package for the button hold time tracker: widths, codes, types, counter step.
// No dependencies.
`default_nettype none

package bhtt_pkg;

  localparam int KEY_W        = 7;   // width of every key mask
  localparam int CNT_W        = 8;   // per-key frame counter width
  localparam int CFG_W        = 8;   // widest configuration register
  localparam int CFG_IDX_W    = 1;   // configuration register index width
  localparam int NUM_KEYS_DEF = 7;
  localparam int DIV_STEPS    = CNT_W;  // one remainder bit per cycle

  localparam logic [CNT_W-1:0] RELEASE_MARK = 8'hFF;
  localparam logic [CNT_W-1:0] FOLD_VALUE   = 8'd2;
  localparam logic [CNT_W-1:0] CNT_ONE      = 8'd1;
  localparam logic [CNT_W-1:0] CNT_ZERO     = 8'd0;

  localparam logic [CFG_W-1:0] HOLD_TARGET_RST   = 8'd1;
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_TARGET   = 1'b0,
    CFG_REPEAT_PERIOD = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_t;

  // Sequencer to lanes
  typedef struct packed {
    logic start;  // transaction accepted: advance the counter
    logic step;   // one remainder iteration
  } lane_ctl_t;

  // Lane to merge
  typedef struct packed {
    logic press;
    logic rel;
    logic held;
    logic rep;
  } lane_flag_t;

  // Counter update for one frame
  function automatic logic [CNT_W-1:0] advance_counter(input logic [CNT_W-1:0] c,
                                                       input logic down);
    logic [CNT_W-1:0] n;
    n = c + CNT_ONE;
    if (down) begin
      return (n == RELEASE_MARK) ? FOLD_VALUE : n;
    end
    if (c == CNT_ZERO || c == RELEASE_MARK) begin
      return CNT_ZERO;
    end
    return RELEASE_MARK;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bhtt_in_if.sv @@
// Input channel of the button hold time tracker: valid/ready plus the key masks.
// Depends on bhtt_pkg.
`default_nettype none

interface bhtt_in_if;
  logic                         valid;
  logic                         ready;
  logic [bhtt_pkg::KEY_W-1:0]   key_mask;
  logic [bhtt_pkg::KEY_W-1:0]   consume_release_mask;

  modport source (output valid, output key_mask, output consume_release_mask,
                  input ready);
  modport sink   (input valid, input key_mask, input consume_release_mask,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bhtt_out_if.sv @@
// Result channel of the button hold time tracker: valid/ready plus event masks.
// Depends on bhtt_pkg.
`default_nettype none

interface bhtt_out_if;
  logic                         valid;
  logic                         ready;
  logic [bhtt_pkg::KEY_W-1:0]   first_press_mask;
  logic [bhtt_pkg::KEY_W-1:0]   release_event_mask;
  logic [bhtt_pkg::KEY_W-1:0]   held_target_mask;
  logic [bhtt_pkg::KEY_W-1:0]   repeat_mask;
  logic [bhtt_pkg::KEY_W-1:0]   level_still_held_mask;
  logic [bhtt_pkg::KEY_W-1:0]   level_released_mask;

  modport source (output valid, output first_press_mask, output release_event_mask,
                  output held_target_mask, output repeat_mask,
                  output level_still_held_mask, output level_released_mask,
                  input ready);
  modport sink   (input valid, input first_press_mask, input release_event_mask,
                  input held_target_mask, input repeat_mask,
                  input level_still_held_mask, input level_released_mask,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bhtt_lane.sv @@
// One key lane: frame counter, event compares and a bit-serial remainder unit.
// Depends on bhtt_pkg.
`default_nettype none

module bhtt_lane (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bhtt_pkg::lane_ctl_t             ctl,
  input  wire logic                            key_down,
  input  wire logic                            consume,
  input  wire logic [bhtt_pkg::CFG_W-1:0]      hold_target,
  input  wire logic [bhtt_pkg::CFG_W-1:0]      repeat_period,
  output bhtt_pkg::lane_flag_t                 flags
);

  localparam int CW = bhtt_pkg::CNT_W;

  logic [CW-1:0] counter_r, counter_nxt;
  logic [CW-1:0] c_new;
  logic [CW-1:0] div_r, div_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          press_r, rel_r, held_r, zero_r;
  logic [CW:0]   rem_sh;
  logic [CW:0]   target;

  // Counter value after this frame, consume applied once the flags are taken
  always_comb begin
    c_new       = bhtt_pkg::advance_counter(counter_r, key_down);
    counter_nxt = (consume && c_new == bhtt_pkg::RELEASE_MARK) ? bhtt_pkg::CNT_ZERO
                                                               : c_new;
    target      = {1'b0, hold_target} + {{CW{1'b0}}, 1'b1};
  end

  // Restoring remainder step: shift in one dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, div_r[CW-1]};
    div_nxt = {div_r[CW-2:0], 1'b0};
    if (rem_sh >= {1'b0, repeat_period}) begin
      rem_nxt = CW'(rem_sh - {1'b0, repeat_period});
    end else begin
      rem_nxt = rem_sh[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= bhtt_pkg::CNT_ZERO;
    end else if (ctl.start) begin
      counter_r <= counter_nxt;
    end
  end

  // Per-frame flags and divider operands
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      press_r <= (c_new == bhtt_pkg::CNT_ONE);
      rel_r   <= (c_new == bhtt_pkg::RELEASE_MARK);
      held_r  <= ({1'b0, c_new} == target);
      zero_r  <= (c_new == bhtt_pkg::CNT_ZERO);
      div_r   <= c_new;
      rem_r   <= bhtt_pkg::CNT_ZERO;
    end else if (ctl.step) begin
      div_r   <= div_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Repeat: every held frame for period 0 or 1, else remainder of one
  always_comb begin
    flags.press = press_r;
    flags.rel   = rel_r;
    flags.held  = held_r;
    if (repeat_period <= bhtt_pkg::CFG_W'(1)) begin
      flags.rep = !rel_r && !zero_r;
    end else begin
      flags.rep = !rel_r && (rem_r == bhtt_pkg::CNT_ONE);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bhtt_merge.sv @@
// Merge stage: gathers lane flags into masks, level masks, output register.
// Depends on bhtt_pkg and bhtt_out_if.
`default_nettype none

module bhtt_merge #(
  parameter int LANES = bhtt_pkg::NUM_KEYS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          load,
  input  wire logic [bhtt_pkg::KEY_W-1:0]    key_mask,
  input  wire bhtt_pkg::lane_flag_t          flags [LANES],
  bhtt_out_if.source                         out_chan
);

  localparam int KW = bhtt_pkg::KEY_W;

  logic [KW-1:0] prev_key_r;
  logic [KW-1:0] still_r, released_r;
  logic [KW-1:0] press_m, rel_m, held_m, rep_m;
  logic          valid_r, valid_nxt;
  logic [KW-1:0] press_r, rel_r, held_r, rep_r, out_still_r, out_rel_lvl_r;

  // Lane flags to masks; keys without a lane stay clear
  for (genvar k = 0; k < KW; k++) begin : g_bits
    if (k < LANES) begin : g_lane
      assign press_m[k] = flags[k].press;
      assign rel_m[k]   = flags[k].rel;
      assign held_m[k]  = flags[k].held;
      assign rep_m[k]   = flags[k].rep;
    end else begin : g_none
      assign press_m[k] = 1'b0;
      assign rel_m[k]   = 1'b0;
      assign held_m[k]  = 1'b0;
      assign rep_m[k]   = 1'b0;
    end
  end

  // Level masks against the previous frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r <= '0;
    end else if (start) begin
      prev_key_r <= key_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      still_r    <= key_mask & prev_key_r;
      released_r <= ~key_mask & prev_key_r;
    end
  end

  // Output register
  assign valid_nxt = load || (valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      press_r       <= press_m;
      rel_r         <= rel_m;
      held_r        <= held_m;
      rep_r         <= rep_m;
      out_still_r   <= still_r;
      out_rel_lvl_r <= released_r;
    end
  end

  assign out_chan.valid                 = valid_r;
  assign out_chan.first_press_mask      = press_r;
  assign out_chan.release_event_mask    = rel_r;
  assign out_chan.held_target_mask      = held_r;
  assign out_chan.repeat_mask           = rep_r;
  assign out_chan.level_still_held_mask = out_still_r;
  assign out_chan.level_released_mask   = out_rel_lvl_r;

endmodule

`default_nettype wire

@@ hw/rtl/button_hold_time_tracker.sv @@
// Top level of the button hold time tracker: config registers, sequencer, lanes.
// Depends on bhtt_pkg, bhtt_in_if, bhtt_out_if, bhtt_lane, bhtt_merge.
//
//   channel   direction  handshake       payload
//   in_chan   sink       valid/ready     key_mask, consume_release_mask
//   out_chan  source     valid/ready     six 7-bit event and level masks
//   cfg_*     write      cfg_we          cfg_index selects, cfg_wdata 8 bits
//
// A transaction passes through the accept, the bit-serial remainder loop in every
// lane (one counter bit per cycle) and then the merge cycle.
// A new transaction is taken while the previous result still waits in the
// output register; the merge cycle waits for that register to drain.
// rst_n is synchronous, active low; counters, previous mask and config reset.
`default_nettype none
`include "button_hold_time_tracker_defines.svh"

module button_hold_time_tracker #(
  parameter int NUM_KEYS = bhtt_pkg::NUM_KEYS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bhtt_in_if.sink                                in_chan,
  bhtt_out_if.source                             out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [bhtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bhtt_pkg::CFG_W-1:0]        cfg_wdata
);

  // Keys past the mask width are always up and never reported: no lane.
  localparam int LANES  = (NUM_KEYS < bhtt_pkg::KEY_W) ? NUM_KEYS : bhtt_pkg::KEY_W;
  localparam int STEP_W = $clog2(bhtt_pkg::DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(bhtt_pkg::DIV_STEPS - 1);

  bhtt_pkg::seq_state_t      state_r, state_nxt;
  logic [STEP_W-1:0]         step_r;
  logic [bhtt_pkg::CFG_W-1:0] hold_target_r, repeat_period_r;
  logic                      accept, step_last, out_free, load;
  bhtt_pkg::lane_ctl_t       lane_ctl;
  bhtt_pkg::lane_flag_t      flags [LANES];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_target_r   <= bhtt_pkg::HOLD_TARGET_RST;
      repeat_period_r <= bhtt_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (bhtt_pkg::cfg_reg_t'(cfg_index))
        bhtt_pkg::CFG_HOLD_TARGET:   hold_target_r   <= cfg_wdata;
        bhtt_pkg::CFG_REPEAT_PERIOD: repeat_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept    = in_chan.valid && in_chan.ready;
  assign step_last = (step_r == STEP_LAST);
  assign out_free  = !out_chan.valid || out_chan.ready;

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bhtt_pkg::ST_IDLE: if (accept) state_nxt = bhtt_pkg::ST_RUN;
      bhtt_pkg::ST_RUN:  if (step_last) state_nxt = bhtt_pkg::ST_DONE;
      bhtt_pkg::ST_DONE: if (out_free) state_nxt = bhtt_pkg::ST_IDLE;
      default:           state_nxt = bhtt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_chan.ready  = (state_r == bhtt_pkg::ST_IDLE);
    lane_ctl.start = in_chan.valid && (state_r == bhtt_pkg::ST_IDLE);
    lane_ctl.step  = (state_r == bhtt_pkg::ST_RUN);
    load           = (state_r == bhtt_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhtt_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_r == bhtt_pkg::ST_RUN) ? step_r + STEP_W'(1) : '0;
    end
  end

  // Key lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    bhtt_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (lane_ctl),
      .key_down      (in_chan.key_mask[k]),
      .consume       (in_chan.consume_release_mask[k]),
      .hold_target   (hold_target_r),
      .repeat_period (repeat_period_r),
      .flags         (flags[k])
    );
  end

  bhtt_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (lane_ctl.start),
    .load     (load),
    .key_mask (in_chan.key_mask),
    .flags    (flags),
    .out_chan (out_chan)
  );

  // Accepted transaction starts the remainder loop
  `BHTT_ASSERT_NXT(a_accept_runs, accept, state_r == bhtt_pkg::ST_RUN, "accept did not start run")
  // Loop ends after its last step
  `BHTT_ASSERT_NXT(a_run_ends, (state_r == bhtt_pkg::ST_RUN) && step_last, state_r == bhtt_pkg::ST_DONE, "run overran")
  // A new result only appears out of the merge cycle
  `BHTT_ASSERT_IMP(a_result_src, $rose(out_chan.valid), $past(state_r == bhtt_pkg::ST_DONE), "result without merge")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for button_hold_time_tracker: directed frames, then random key traffic.
// Results are checked against a per-key counter tracker kept in this bench, or against a typed row's own answer.
// Depends on bhtt_pkg, bhtt_in_if, bhtt_out_if and the button_hold_time_tracker RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bhtt_pkg::*;

  localparam int NKEYS       = 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_FRAMES = 1100;
  localparam int NUM_PHASES  = 7;
  localparam int SCRIPT_LEN  = 24;
  localparam int DRAIN_WAIT  = 16;

  // One frame's event masks, in the order of the result channel
  typedef struct packed {
    logic [KEY_W-1:0] press;
    logic [KEY_W-1:0] rel;
    logic [KEY_W-1:0] held;
    logic [KEY_W-1:0] rep;
    logic [KEY_W-1:0] still;
    logic [KEY_W-1:0] released;
  } event_masks_t;

  typedef enum logic {ROW_FRAME, ROW_CONFIG} row_kind_t;

  // Stimulus row: a frame or a register setting; typed rows carry their own answer
  typedef struct packed {
    row_kind_t        kind;
    logic [KEY_W-1:0] keys;
    logic [KEY_W-1:0] consume;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] period;
    logic             typed;
    event_masks_t     events;
  } row_t;

  localparam event_masks_t NO_EVENTS = '0;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bhtt_in_if  in_if ();
  bhtt_out_if out_if ();

  button_hold_time_tracker DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Tracker state: per-key frame counters, last key mask, register copies
  logic [CNT_W-1:0] frame_cnt [NKEYS];
  logic [KEY_W-1:0] last_keys;
  logic [CFG_W-1:0] hold_target;
  logic [CFG_W-1:0] rep_period;

  row_t         frames_in_flight [$];
  event_masks_t masks_due [$];
  int           errors;
  int           cycles;
  int           send_idle_pct;
  int           recv_idle_pct;

  // Random key traffic: per-key remaining hold and gap lengths
  int               hold_left [NKEYS];
  int               gap_left  [NKEYS];
  logic [KEY_W-1:0] last_sent;

  // Directed part: typed answers only where they follow from reset directly
  row_t script [SCRIPT_LEN] = '{
    '{ROW_FRAME,  7'h00, 7'h00, 8'd0,   8'd0,   1'b1, NO_EVENTS},
    '{ROW_FRAME,  7'h7F, 7'h00, 8'd0,   8'd0,   1'b1,
      '{7'h7F, 7'h00, 7'h00, 7'h7F, 7'h00, 7'h00}},
    '{ROW_FRAME,  7'h7F, 7'h00, 8'd0,   8'd0,   1'b1,
      '{7'h00, 7'h00, 7'h7F, 7'h7F, 7'h7F, 7'h00}},
    '{ROW_FRAME,  7'h00, 7'h00, 8'd0,   8'd0,   1'b1,
      '{7'h00, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h7F}},
    // press right after the release frame: counter wraps to idle, no press
    '{ROW_FRAME,  7'h7F, 7'h00, 8'd0,   8'd0,   1'b1, NO_EVENTS},
    '{ROW_FRAME,  7'h7F, 7'h00, 8'd0,   8'd0,   1'b1,
      '{7'h7F, 7'h00, 7'h00, 7'h7F, 7'h7F, 7'h00}},
    '{ROW_FRAME,  7'h00, 7'h55, 8'd0,   8'd0,   1'b1,
      '{7'h00, 7'h7F, 7'h00, 7'h00, 7'h00, 7'h7F}},
    // consumed keys start a fresh press, the others wrap
    '{ROW_FRAME,  7'h7F, 7'h00, 8'd0,   8'd0,   1'b1,
      '{7'h55, 7'h00, 7'h00, 7'h55, 7'h00, 7'h00}},
    '{ROW_FRAME,  7'h00, 7'h7F, 8'd0,   8'd0,   1'b1,
      '{7'h00, 7'h55, 7'h00, 7'h00, 7'h00, 7'h7F}},
    // consume on idle keys is ignored
    '{ROW_FRAME,  7'h00, 7'h7F, 8'd0,   8'd0,   1'b1, NO_EVENTS},
    // hold target 254: held fires in the release frame
    '{ROW_CONFIG, 7'h00, 7'h00, 8'd254, 8'd1,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h01, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h00, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h7F, 7'h2A, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h2A, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    // hold target 255 never fires
    '{ROW_CONFIG, 7'h00, 7'h00, 8'd255, 8'd255, 1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h7F, 7'h7F, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h7F, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h00, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_CONFIG, 7'h00, 7'h00, 8'd0,   8'd2,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h55, 7'h55, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h55, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h55, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS},
    '{ROW_FRAME,  7'h2A, 7'h00, 8'd0,   8'd0,   1'b0, NO_EVENTS}
  };

  // Clock, 8 ns period
  always begin
    clk = 1'b0;
    #4ns;
    clk = 1'b1;
    #4ns;
  end

  // Advance every key counter by one frame and derive the event masks
  function automatic event_masks_t track_frame(input logic [KEY_W-1:0] keys,
                                               input logic [KEY_W-1:0] consume);
    event_masks_t     ev;
    logic [CNT_W-1:0] c;
    logic [CNT_W:0]   target;
    ev     = NO_EVENTS;
    target = {1'b0, hold_target} + 1'b1;
    for (int k = 0; k < NKEYS; k++) begin
      c = frame_cnt[k];
      if (keys[k]) begin
        c = c + 1'b1;
        if (c == RELEASE_MARK) c = FOLD_VALUE;
      end else if (c == CNT_ZERO || c == RELEASE_MARK) begin
        c = CNT_ZERO;
      end else begin
        c = RELEASE_MARK;
      end
      ev.press[k] = (c == CNT_ONE);
      ev.rel[k]   = (c == RELEASE_MARK);
      ev.held[k]  = ({1'b0, c} == target);
      if (c == RELEASE_MARK)
        ev.rep[k] = 1'b0;
      else if (rep_period <= 8'd1)
        ev.rep[k] = (c != CNT_ZERO);
      else
        ev.rep[k] = ((c % rep_period) == CNT_ONE);
      // software read the release: back to idle right away
      if (consume[k] && c == RELEASE_MARK) c = CNT_ZERO;
      frame_cnt[k] = c;
    end
    ev.still    = keys & last_keys;
    ev.released = ~keys & last_keys;
    last_keys   = keys;
    return ev;
  endfunction

  function automatic int check_mask(input string name, input logic [KEY_W-1:0] want,
                                    input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Accepted frames feed the tracker; accepted results are checked in order
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        if (frames_in_flight.size() == 0) begin
          $error("input transaction with no frame queued");
          errors++;
        end else begin
          row_t         fr;
          event_masks_t ev;
          fr = frames_in_flight.pop_front();
          ev = track_frame(in_if.key_mask, in_if.consume_release_mask);
          masks_due.push_back(fr.typed ? fr.events : ev);
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (masks_due.size() == 0) begin
          $error("result transaction with no frame outstanding");
          errors++;
        end else begin
          event_masks_t want;
          want = masks_due.pop_front();
          errors += check_mask("first_press_mask", want.press, out_if.first_press_mask);
          errors += check_mask("release_event_mask", want.rel, out_if.release_event_mask);
          errors += check_mask("held_target_mask", want.held, out_if.held_target_mask);
          errors += check_mask("repeat_mask", want.rep, out_if.repeat_mask);
          errors += check_mask("level_still_held_mask", want.still,
                               out_if.level_still_held_mask);
          errors += check_mask("level_released_mask", want.released,
                               out_if.level_released_mask);
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_if.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  task automatic drive_frame(input row_t r);
    if (int'($urandom_range(99)) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(99)) < send_idle_pct);
    end
    frames_in_flight.push_back(r);
    in_if.valid                <= 1'b1;
    in_if.key_mask             <= r.keys;
    in_if.consume_release_mask <= r.consume;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (frames_in_flight.size() != 0 || masks_due.size() != 0);
  endtask

  // Write both registers back to back; block is idle here
  task automatic set_config(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] period);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOLD_TARGET;
    cfg_wdata <= hold;
    @(posedge clk);
    hold_target = hold;
    cfg_index <= CFG_REPEAT_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    rep_period = period;
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_hold();
    int r;
    r = int'($urandom_range(99));
    if (r < 55) return int'($urandom_range(6, 1));
    if (r < 85) return int'($urandom_range(40, 7));
    return int'($urandom_range(300, 256));  // long enough to fold past 254
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(99));
    if (r < 60) return 1;              // press right after the release frame
    if (r < 85) return int'($urandom_range(4, 2));
    return int'($urandom_range(20, 5));
  endfunction

  // Next key mask from per-key press/release runs
  function automatic logic [KEY_W-1:0] next_keys();
    logic [KEY_W-1:0] keys;
    keys = '0;
    for (int k = 0; k < NKEYS; k++) begin
      if (hold_left[k] == 0 && gap_left[k] == 0) begin
        hold_left[k] = pick_hold();
        gap_left[k]  = pick_gap();
      end
      if (hold_left[k] > 0) begin
        keys[k] = 1'b1;
        hold_left[k]--;
      end else begin
        gap_left[k]--;
      end
    end
    return keys;
  endfunction

  // Main sequence
  initial begin
    row_t             r;
    int               sent;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] period;

    rst_n                      = 1'b0;
    in_if.valid                = 1'b0;
    in_if.key_mask             = '0;
    in_if.consume_release_mask = '0;
    out_if.ready               = 1'b0;
    cfg_we                     = 1'b0;
    cfg_index                  = CFG_HOLD_TARGET;
    cfg_wdata                  = '0;
    errors                     = 0;
    cycles                     = 0;
    send_idle_pct              = 24;
    recv_idle_pct              = 67;
    last_sent                  = '0;
    sent                       = 0;
    for (int k = 0; k < NKEYS; k++) begin
      frame_cnt[k] = CNT_ZERO;
      hold_left[k] = 0;
      gap_left[k]  = 0;
    end
    last_keys   = '0;
    hold_target = HOLD_TARGET_RST;
    rep_period  = REPEAT_PERIOD_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows
    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG) begin
        wait_drained();
        set_config(script[i].hold, script[i].period);
      end else begin
        drive_frame(script[i]);
      end
    end

    // Random traffic, one register setting per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin hold = 8'd1;   period = 8'd0;   end
        1: begin hold = 8'd254; period = 8'd1;   end
        2: begin hold = 8'd255; period = 8'd255; end
        3: begin hold = 8'd0;   period = 8'd2;   end
        4: begin hold = 8'd200; period = 8'd254; end
        5: begin
          hold   = CFG_W'($urandom_range(255));
          period = CFG_W'($urandom_range(255));
        end
        default: begin
          hold   = CFG_W'($urandom_range(12, 1));
          period = CFG_W'($urandom_range(9, 2));
        end
      endcase
      wait_drained();
      set_config(hold, period);
      for (int n = 0; n < RAND_FRAMES / NUM_PHASES; n++) begin
        // idling: sender light/receiver heavy, then swapped, then none
        if (sent < RAND_FRAMES / 3) begin
          send_idle_pct = 24;
          recv_idle_pct = 67;
        end else if (sent < 2 * RAND_FRAMES / 3) begin
          send_idle_pct = 67;
          recv_idle_pct = 24;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (sent == RAND_FRAMES / 2) wait_drained();
        r       = '0;
        r.kind  = ROW_FRAME;
        r.keys  = next_keys();
        // some noise frames that break the press/release runs
        if ($urandom_range(99) < 10) r.keys = KEY_W'($urandom_range(127));
        if ($urandom_range(1) == 1)
          r.consume = last_sent & ~r.keys;
        else
          r.consume = KEY_W'($urandom_range(127));
        last_sent = r.keys;
        drive_frame(r);
        sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
